// ===== rtl/sha256_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_pkg
// shared types and constants of the sha-256 stream hasher
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int BLK_BITS  = 512;
    localparam int WORD_BITS = 32;
    localparam int NUM_WORDS = 8;

    localparam logic [5:0] FILL_LAST = 6'd63;   // last byte slot of a block
    localparam logic [5:0] LEN_POS   = 6'd56;   // first byte slot of the length
    localparam logic [5:0] RND_LAST  = 6'd63;
    localparam logic [2:0] WORD_LAST = 3'd7;
    localparam logic [7:0] PAD_BYTE  = 8'h80;

    localparam logic [31:0] INIT_H [NUM_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_PAD,
        SEL_ZERO,
        SEL_LEN
    } t_byte_sel;

    typedef struct packed {
        logic      load_byte;
        t_byte_sel byte_sel;
        logic [2:0] len_idx;
        logic      len_inc;
        logic      len_clr;
        logic      work_init;
        logic      round_en;
        logic [5:0] rnd_idx;
        logic      chain_add;
        logic      out_shift;
        logic [2:0] out_idx;
    } t_dp_cmd;

endpackage

// ===== rtl/sha256_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_ctrl
// sequencer: byte gathering, padding, round count and digest output
// ----------------------------------------------------------------------------
module sha256_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_present,
    input  logic                 i_in_last,
    output logic                 o_in_ready,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [2:0]           o_out_idx,
    output logic                 o_out_last,
    output sha256_pkg::t_dp_cmd  o_cmd
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_fill, n_fill;
    logic [5:0] r_rnd, n_rnd;
    logic [2:0] r_widx, n_widx;
    logic       r_finishing, n_finishing;
    logic       r_first, n_first;
    logic       r_len_ok, n_len_ok;
    logic       r_last, n_last;
    logic       r_out_valid, n_out_valid;
    logic       len_ok_now;
    t_dp_cmd    cmd;

    always_comb begin
        cmd          = '0;
        cmd.byte_sel = SEL_DATA;
        n_state      = r_state;
        n_fill       = r_fill;
        n_rnd        = r_rnd;
        n_widx       = r_widx;
        n_finishing  = r_finishing;
        n_first      = r_first;
        n_len_ok     = r_len_ok;
        n_last       = r_last;
        n_out_valid  = r_out_valid;
        len_ok_now   = r_first ? (r_fill < LEN_POS) : r_len_ok;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_present) begin
                        cmd.load_byte = 1'b1;
                        cmd.len_inc   = 1'b1;
                        n_fill        = r_fill + 6'd1;
                        if (r_fill == FILL_LAST) begin
                            cmd.work_init = 1'b1;
                            n_rnd         = '0;
                            n_state       = S_ROUND;
                        end
                    end
                    if (i_in_last) begin
                        n_finishing = 1'b1;
                        n_first     = 1'b1;
                        n_len_ok    = 1'b0;
                        n_last      = 1'b0;
                        if (!(i_in_present && r_fill == FILL_LAST)) begin
                            n_state = S_PAD;
                        end
                    end
                end
            end
            S_PAD: begin
                cmd.load_byte = 1'b1;
                cmd.len_idx   = r_fill[2:0];
                if (r_first) begin
                    cmd.byte_sel = SEL_PAD;
                end else if (r_fill >= LEN_POS && r_len_ok) begin
                    cmd.byte_sel = SEL_LEN;
                end else begin
                    cmd.byte_sel = SEL_ZERO;
                end
                n_first  = 1'b0;
                n_len_ok = len_ok_now;
                n_fill   = r_fill + 6'd1;
                if (r_fill == FILL_LAST) begin
                    // length lands in the block after a pad that spilled over
                    cmd.work_init = 1'b1;
                    n_rnd         = '0;
                    n_state       = S_ROUND;
                    n_last        = len_ok_now;
                    n_len_ok      = 1'b1;
                end
            end
            S_ROUND: begin
                cmd.round_en = 1'b1;
                cmd.rnd_idx  = r_rnd;
                n_rnd        = r_rnd + 6'd1;
                if (r_rnd == RND_LAST) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                cmd.chain_add = 1'b1;
                if (r_finishing) begin
                    if (r_last) begin
                        cmd.len_clr = 1'b1;
                        n_state     = S_OUT;
                        n_out_valid = 1'b1;
                        n_widx      = '0;
                        n_finishing = 1'b0;
                        n_last      = 1'b0;
                    end else begin
                        n_state = S_PAD;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    cmd.out_shift = 1'b1;
                    cmd.out_idx   = r_widx;
                    n_widx        = r_widx + 3'd1;
                    if (r_widx == WORD_LAST) begin
                        n_out_valid = 1'b0;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_rnd       <= '0;
            r_widx      <= '0;
            r_finishing <= 1'b0;
            r_first     <= 1'b0;
            r_len_ok    <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_rnd       <= n_rnd;
            r_widx      <= n_widx;
            r_finishing <= n_finishing;
            r_first     <= n_first;
            r_len_ok    <= n_len_ok;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_idx   = r_widx;
    assign o_out_last  = (r_widx == WORD_LAST);
    assign o_cmd       = cmd;

endmodule

// ===== rtl/sha256_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_dp
// datapath: block shift register / schedule window, round unit, chain, length
// ----------------------------------------------------------------------------
module sha256_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha256_pkg::t_dp_cmd  i_cmd,
    input  logic [7:0]           i_data_byte,
    output logic [31:0]          o_digest_word
);
    import sha256_pkg::*;

    logic [BLK_BITS-1:0]  r_blk;
    logic [WORD_BITS-1:0] r_work  [NUM_WORDS];
    logic [WORD_BITS-1:0] r_chain [NUM_WORDS];
    logic [63:0]          r_bit_len;

    logic [7:0]  byte_in;
    logic [5:0]  len_lsb;
    logic [31:0] w0, w1, w9, w14, w_new;
    logic [31:0] t1, t2;
    logic [31:0] a, b, c, d, e, f, g, h;

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        big_s0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        big_s1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        small_s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        small_s1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    // length bytes go out most significant first
    assign len_lsb = {~i_cmd.len_idx, 3'b000};

    always_comb begin
        case (i_cmd.byte_sel)
            SEL_DATA: byte_in = i_data_byte;
            SEL_PAD:  byte_in = PAD_BYTE;
            SEL_ZERO: byte_in = 8'h00;
            SEL_LEN:  byte_in = r_bit_len[len_lsb +: 8];
            default:  byte_in = 8'h00;
        endcase
    end

    // schedule window: word t sits at the top of the block register
    assign w0    = r_blk[BLK_BITS-1       -: WORD_BITS];
    assign w1    = r_blk[BLK_BITS-1-32    -: WORD_BITS];
    assign w9    = r_blk[BLK_BITS-1-9*32  -: WORD_BITS];
    assign w14   = r_blk[BLK_BITS-1-14*32 -: WORD_BITS];
    assign w_new = w0 + small_s0(w1) + w9 + small_s1(w14);

    assign a = r_work[0];
    assign b = r_work[1];
    assign c = r_work[2];
    assign d = r_work[3];
    assign e = r_work[4];
    assign f = r_work[5];
    assign g = r_work[6];
    assign h = r_work[7];

    assign t1 = h + big_s1(e) + ((e & f) ^ (~e & g)) + ROUND_K[i_cmd.rnd_idx] + w0;
    assign t2 = big_s0(a) + ((a & b) ^ (a & c) ^ (b & c));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_blk <= {r_blk[BLK_BITS-9:0], byte_in};
        end else if (i_cmd.round_en) begin
            r_blk <= {r_blk[BLK_BITS-WORD_BITS-1:0], w_new};
        end
        if (i_cmd.work_init) begin
            for (int j = 0; j < NUM_WORDS; j++) begin
                r_work[j] <= r_chain[j];
            end
        end else if (i_cmd.round_en) begin
            r_work[0] <= t1 + t2;
            r_work[1] <= a;
            r_work[2] <= b;
            r_work[3] <= c;
            r_work[4] <= d + t1;
            r_work[5] <= e;
            r_work[6] <= f;
            r_work[7] <= g;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_WORDS; j++) begin
                r_chain[j] <= INIT_H[j];
            end
            r_bit_len <= '0;
        end else begin
            if (i_cmd.chain_add) begin
                for (int j = 0; j < NUM_WORDS; j++) begin
                    r_chain[j] <= r_chain[j] + r_work[j];
                end
            end else if (i_cmd.out_shift) begin
                // rotate digest out, refill with initial hash behind it
                for (int j = 0; j < NUM_WORDS - 1; j++) begin
                    r_chain[j] <= r_chain[j+1];
                end
                r_chain[NUM_WORDS-1] <= INIT_H[i_cmd.out_idx];
            end
            if (i_cmd.len_clr) begin
                r_bit_len <= '0;
            end else if (i_cmd.len_inc) begin
                r_bit_len <= r_bit_len + 64'd8;
            end
        end
    end

    assign o_digest_word = r_chain[0];

endmodule

// ===== rtl/sha256_stream_hasher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// sha-256 over a byte stream, digest emitted as eight 32-bit words
// ----------------------------------------------------------------------------
//
// channel   dir  tdata                         tuser         tlast
// s_axis    in   [7:0] data byte               byte present  end of message
// m_axis    out  [31:0] word, [34:32] index    -             last digest word
//
// the block takes one byte request per cycle while gathering; the 64th byte of a
// block starts a compression (64 rounds of the single round unit plus the chain add)
// an end mark brings the pad, zero and length bytes, one per cycle (up to 72),
// then one or two block compressions, then eight output requests
// input is taken only while gathering; digest words wait in the chain on tready
// reset is synchronous active low and restores the initial hash value
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input request
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] byte_present
    input  logic        i_s_axis_tlast,   // end_of_message
    // digest request
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        o_m_axis_tlast    // last_word
);
    import sha256_pkg::*;

    t_dp_cmd     cmd;
    logic [2:0]  out_idx;
    logic [31:0] digest_word;

    // sequencer owns all handshake decisions
    sha256_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .i_in_present (i_s_axis_tuser),
        .i_in_last    (i_s_axis_tlast),
        .o_in_ready   (o_s_axis_tready),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_idx    (out_idx),
        .o_out_last   (o_m_axis_tlast),
        .o_cmd        (cmd)
    );

    // datapath follows the command word only
    sha256_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_s_axis_tdata),
        .o_digest_word (digest_word)
    );

    assign o_m_axis_tdata = {5'b00000, out_idx, digest_word};

`ifndef SYNTHESIS
    // never take input while a digest is going out
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while digest pending");

    // an end mark always stops input for padding and compression
    a_end_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast) |=> !o_s_axis_tready)
        else $error("input taken right after end of message");

    // after the last digest word the block is ready for the next message
    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |=>
        (o_s_axis_tready && !o_m_axis_tvalid))
        else $error("not idle after last digest word");

    // a digest word that is not the last is followed by another one
    a_words_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |=>
        (o_m_axis_tvalid && o_m_axis_tdata[34:32] == $past(o_m_axis_tdata[34:32]) + 3'd1))
        else $error("digest word sequence broken");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sha-256 stream hasher core
//
// byte requests go in on s_axis, digest words come back on m_axis
// directed table first: idle requests, empty messages, "abc" split two
// ways, single bytes at the value extremes, a three-byte message 80 7f 01
// random whole messages follow, lengths biased toward padding and block edges,
// with idle noise requests mixed in
// a local sha-256 model predicts every digest word that no typed digest gives
// both sides stall at random except for one stretch without gaps
// ----------------------------------------------------------------------------
module tb_top;

    localparam int REQ_TARGET     = 250;   // byte and end-mark requests in random phase
    localparam int STALL_PCT      = 26;    // idle cycles per hundred on each side
    localparam int STEADY_FIRST   = 120;   // no-gap stretch, counted in requests
    localparam int STEADY_LAST    = 200;
    localparam int WATCHDOG_LIMIT = 5000;  // cycles without any accepted request
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_PRINTS     = 40;

    typedef logic [31:0] t_word;

    typedef struct packed {
        t_word      word;
        logic [2:0] index;
        logic       last;
    } t_digest_beat;

    // one directed request; a typed digest stands in for the prediction
    typedef struct packed {
        logic [7:0]   data;
        logic         present;
        logic         eom;
        logic         typed;
        logic [255:0] digest;
    } t_stim_row;

    localparam logic [255:0] DIGEST_EMPTY =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam logic [255:0] DIGEST_ABC =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

    localparam t_word SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // lengths that land on the padding and block edges
    localparam int EDGE_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

    localparam int N_DIRECTED = 17;
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        // idle requests right after reset, data must be ignored
        '{8'h00, 1'b0, 1'b0, 1'b0, 256'h0},
        '{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},
        // empty message from reset state
        '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
        // "abc" with an idle request inside and a separate end mark
        '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'ha5, 1'b0, 1'b0, 1'b0, 256'h0},
        '{8'h63, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_ABC},
        // one-byte messages at the value extremes, end mark on the byte
        '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
        '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
        // "abc" again, end mark riding on the last byte
        '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, DIGEST_ABC},
        // empty message with junk on the data lines
        '{8'hff, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
        // three-byte message 80 7f 01, end mark on the last byte
        '{8'h80, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h7f, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h01, 1'b1, 1'b1, 1'b0, 256'h0}
    };

    // clock and reset
    logic i_clk;
    logic rst_n;

    // input request side
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] data_byte
    logic        s_axis_tuser;    // [0] byte_present
    logic        s_axis_tlast;    // end_of_message

    // digest request side
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;    // [31:0] digest_word, [34:32] word_index, zero fill
    logic        m_axis_tlast;    // last_word

    // random stall control, set inside the no-gap stretch
    logic steady;

    // hash model state
    t_word        hash_state [8];
    logic [7:0]   block_buf  [64];
    int           block_fill;
    logic [63:0]  msg_bits;
    t_digest_beat digest_q [$];

    // run statistics
    int mismatches;
    int requests_sent;
    int payload_sent;     // requests that carry a byte or an end mark
    int messages_done;
    int longest_msg;
    int words_checked;
    int idle_cycles;

    sha256_stream_hasher_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_s_axis_tlast  (s_axis_tlast),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        end
    endtask

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one sha-256 compression of block_buf into hash_state
    function automatic void compress_block();
        t_word w [64];
        t_word v [8];
        t_word s0;
        t_word s1;
        t_word t1;
        t_word t2;
        for (int i = 0; i < 16; i++) begin
            w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        v = hash_state;
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) begin
            hash_state[i] += v[i];
        end
    endfunction

    function automatic void restart_message();
        hash_state = SHA_IV;
        block_fill = 0;
        msg_bits   = '0;
    endfunction

    // applies one accepted request to the hash model; an end mark queues the
    // eight digest words, taken from a typed digest when one is given
    function automatic void absorb_request(input logic [7:0] data, input logic present,
                                           input logic eom, input logic typed,
                                           input logic [255:0] digest);
        logic [63:0]  total;
        int           pos;
        t_digest_beat beat;
        if (present) begin
            block_buf[block_fill] = data;
            block_fill++;
            if (block_fill == 64) begin
                compress_block();
                msg_bits   += 64'd512;
                block_fill = 0;
            end
        end
        if (eom) begin
            total = msg_bits + 64'(block_fill) * 64'd8;
            pos = block_fill;
            block_buf[pos] = 8'h80;
            pos++;
            // no room left for the length field: pad out and spill into a second block
            if (pos > 56) begin
                while (pos < 64) begin
                    block_buf[pos] = 8'h00;
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < 56) begin
                block_buf[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++) begin
                block_buf[63-i] = total[8*i +: 8];
            end
            compress_block();
            for (int i = 0; i < 8; i++) begin
                beat.word  = typed ? digest[255-32*i -: 32] : hash_state[i];
                beat.index = 3'(i);
                beat.last  = (i == 7);
                digest_q.push_back(beat);
            end
            messages_done++;
            restart_message();
        end
    endfunction

    // drives one request from a falling edge, with random idle cycles in front,
    // and holds it until the block takes it
    task automatic send_request(input logic [7:0] data, input logic present, input logic eom,
                                input logic typed, input logic [255:0] digest);
        @(negedge i_clk);
        while (!steady && ($urandom_range(0, 99) < STALL_PCT)) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= present;
        s_axis_tlast  <= eom;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        absorb_request(data, present, eom, typed, digest);
        requests_sent++;
        if (present || eom) begin
            payload_sent++;
        end
    endtask

    // digest side back-pressure, changed on the falling edge
    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
    end

    // digest word checker
    always @(posedge i_clk) begin : digest_check
        t_digest_beat want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            words_checked++;
            if (digest_q.size() == 0) begin
                report_mismatch("digest word with nothing pending", m_axis_tdata[31:0], '0);
            end else begin
                want = digest_q.pop_front();
                if (m_axis_tdata[31:0] !== want.word) begin
                    report_mismatch("digest_word", m_axis_tdata[31:0], want.word);
                end
                if (m_axis_tdata[34:32] !== want.index) begin
                    report_mismatch("word_index", 32'(m_axis_tdata[34:32]), 32'(want.index));
                end
                if (m_axis_tlast !== want.last) begin
                    report_mismatch("last_word", 32'(m_axis_tlast), 32'(want.last));
                end
            end
        end
    end

    // watchdog: any accepted request on either side restarts the count
    always @(posedge i_clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int  msg_len;
        bit  eom_on_byte;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        steady        = 1'b0;
        mismatches    = 0;
        requests_sent = 0;
        payload_sent  = 0;
        messages_done = 0;
        longest_msg   = 0;
        words_checked = 0;
        restart_message();
        for (int i = 0; i < 64; i++) begin
            block_buf[i] = 8'h00;
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < N_DIRECTED; r++) begin
            send_request(DIRECTED[r].data, DIRECTED[r].present, DIRECTED[r].eom,
                         DIRECTED[r].typed, DIRECTED[r].digest);
        end

        // random whole messages, lengths biased toward block edges
        payload_sent = 0;
        while (payload_sent < REQ_TARGET) begin
            steady = (payload_sent >= STEADY_FIRST) && (payload_sent < STEADY_LAST);
            if ($urandom_range(0, 4) == 0) begin
                msg_len = EDGE_LENS[$urandom_range(0, 7)];
            end else begin
                msg_len = $urandom_range(0, 24);
            end
            if (msg_len > longest_msg) begin
                longest_msg = msg_len;
            end
            eom_on_byte = (msg_len > 0) && ($urandom_range(0, 1) == 1);
            for (int b = 0; b < msg_len; b++) begin
                // noise: idle request with junk data
                if ($urandom_range(0, 99) < 8) begin
                    send_request(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
                end
                send_request(8'($urandom), 1'b1, eom_on_byte && (b == msg_len - 1),
                             1'b0, '0);
            end
            if (!eom_on_byte) begin
                send_request(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
            end
        end
        steady = 1'b0;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // drain; the watchdog bounds this wait
        while (digest_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (digest_q.size() != 0) begin
            report_mismatch("digest words never produced", digest_q.size(), '0);
        end

        $display("sent %0d requests over %0d messages, longest random message %0d bytes",
                 requests_sent, messages_done, longest_msg);
        $display("checked %0d digest words, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
